// ===== design/pap_pkg.sv =====
package pap_pkg;

    typedef enum logic [1:0] {
        K_ASN  = 2'd0,
        K_RAW  = 2'd1,
        K_DONE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_TRUNC  = 3'd1,
        ST_WKNOWN = 3'd2,
        ST_FLAGS  = 3'd3,
        ST_LEN    = 3'd4,
        ST_ORIGIN = 3'd5,
        ST_PATH   = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        PH_FLAGS = 5'b00001,
        PH_TYPE  = 5'b00010,
        PH_LEN1  = 5'b00100,
        PH_LEN2  = 5'b01000,
        PH_VALUE = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        SG_TYPE  = 3'b001,
        SG_COUNT = 3'b010,
        SG_ASN   = 3'b100
    } t_seg;

    localparam logic [7:0] T_ORIGIN  = 8'd1;
    localparam logic [7:0] T_ASPATH  = 8'd2;
    localparam logic [7:0] T_NEXTHOP = 8'd3;
    localparam logic [7:0] T_MED     = 8'd4;
    localparam logic [7:0] T_LPREF   = 8'd5;
    localparam logic [7:0] T_ATOMIC  = 8'd6;
    localparam logic [7:0] T_AGGR    = 8'd7;
    localparam logic [7:0] T_COMM    = 8'd8;
    localparam logic [7:0] T_AS4PATH = 8'd17;
    localparam logic [7:0] T_AS4AGGR = 8'd18;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  attr_type;
        logic [3:0]  attr_flags;
        logic [2:0]  status;
        logic [7:0]  segment_type;
        logic [31:0] data;
        logic [31:0] agg_asn;
        logic [16:0] consumed;
        logic        run_end;
    } t_result;

    // Up to two results caused by one input beat.
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_pair;

endpackage

// ===== design/pap_in_if.sv =====
interface pap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== design/pap_out_if.sv =====
interface pap_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  attr_type;
    logic [3:0]  attr_flags;
    logic [2:0]  status;
    logic [7:0]  segment_type;
    logic [31:0] data;
    logic [31:0] agg_asn;
    logic [16:0] consumed;
    logic        run_end;
    modport source (output valid, output kind, output attr_type, output attr_flags,
                    output status, output segment_type, output data,
                    output agg_asn, output consumed, output run_end,
                    input ready);
    modport sink   (input valid, input kind, input attr_type, input attr_flags,
                    input status, input segment_type, input data,
                    input agg_asn, input consumed, input run_end,
                    output ready);
endinterface

// ===== design/pap_front.sv =====
module pap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_four_byte_as,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output pap_pkg::t_pair    o_pair
);
    pap_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_flags, n_flags;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_vlen, n_vlen;
    logic [15:0] r_vcnt, n_vcnt;
    pap_pkg::t_seg r_sph, n_sph;
    logic [7:0]  r_segt, n_segt;
    logic [10:0] r_sleft, n_sleft;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_sec, n_sec;
    logic [2:0]  r_pend, n_pend;
    logic        r_disc, n_disc;

    logic fire;
    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready;

    function automatic logic fbad(input logic [3:0] f, input logic o, input logic t);
        return (f[3] != o) || (f[2] != t) || (f[1:0] != 2'b00);
    endfunction

    function automatic logic [2:0] fixchk(input logic [15:0] l, input logic [15:0] w,
                                          input logic [3:0] f, input logic o,
                                          input logic t);
        if (l < w) return pap_pkg::ST_TRUNC;
        if (l != w) return pap_pkg::ST_LEN;
        return fbad(f, o, t) ? pap_pkg::ST_FLAGS : pap_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] hstat(input logic [7:0] ty, input logic [3:0] f,
                                         input logic [15:0] l, input logic fb);
        unique case (ty)
            pap_pkg::T_ORIGIN:  return fixchk(l, 16'd1, f, 1'b0, 1'b1);
            pap_pkg::T_ASPATH:  return fbad(f, 1'b0, 1'b1) ? pap_pkg::ST_FLAGS : pap_pkg::ST_OK;
            pap_pkg::T_NEXTHOP: return fixchk(l, 16'd4, f, 1'b0, 1'b1);
            pap_pkg::T_MED:     return fixchk(l, 16'd4, f, 1'b1, 1'b0);
            pap_pkg::T_LPREF:   return fixchk(l, 16'd4, f, 1'b0, 1'b0);
            pap_pkg::T_ATOMIC:  return (l != 16'd0) ? pap_pkg::ST_LEN :
                                       (fbad(f, 1'b0, 1'b0) ? pap_pkg::ST_FLAGS : pap_pkg::ST_OK);
            pap_pkg::T_AGGR:    return fixchk(l, fb ? 16'd8 : 16'd6, f, 1'b1, 1'b1);
            pap_pkg::T_COMM:    return fixchk(l, 16'd4, f, 1'b1, 1'b1);
            pap_pkg::T_AS4PATH: return fbad(f, 1'b1, 1'b1) ? pap_pkg::ST_FLAGS : pap_pkg::ST_OK;
            pap_pkg::T_AS4AGGR: return fixchk(l, 16'd8, f, 1'b1, 1'b1);
            default: begin
                if (!f[3] && f[2]) return pap_pkg::ST_WKNOWN;
                if (f[3] && !f[2] && f[1]) return pap_pkg::ST_FLAGS;
                return pap_pkg::ST_OK;
            end
        endcase
    endfunction

    function automatic logic hasval(input logic [7:0] t);
        return t == pap_pkg::T_ORIGIN || t == pap_pkg::T_NEXTHOP || t == pap_pkg::T_MED ||
               t == pap_pkg::T_LPREF || t == pap_pkg::T_AGGR || t == pap_pkg::T_COMM ||
               t == pap_pkg::T_AS4AGGR;
    endfunction

    function automatic pap_pkg::t_result mk(input logic [1:0] k, input logic [7:0] ty,
                                            input logic [3:0] f, input logic [2:0] s,
                                            input logic [7:0] sg, input logic [31:0] d,
                                            input logic [31:0] a, input logic [16:0] c);
        pap_pkg::t_result r;
        r.kind = k; r.attr_type = ty; r.attr_flags = f; r.status = s;
        r.segment_type = sg; r.data = d; r.agg_asn = a; r.consumed = c;
        r.run_end = 1'b0;
        return r;
    endfunction

    logic            is_path, known, sz4;
    logic [2:0]      hs;
    logic [15:0]     len_now;
    logic [16:0]     hl;
    logic [16:0]     alen, vsum;
    logic [15:0]     cnt1;
    logic [31:0]     asm_sh;
    logic [10:0]     sl1;
    logic            mod0;
    logic [1:0]      nres;
    pap_pkg::t_result res [2];

    always_comb begin
        n_phase = r_phase; n_flags = r_flags; n_type = r_type; n_vlen = r_vlen;
        n_vcnt = r_vcnt; n_sph = r_sph; n_segt = r_segt; n_sleft = r_sleft;
        n_asm = r_asm; n_sec = r_sec; n_pend = r_pend; n_disc = r_disc;
        nres = 2'd0;
        res[0] = '0; res[1] = '0;
        is_path = (r_type == pap_pkg::T_ASPATH) || (r_type == pap_pkg::T_AS4PATH);
        known = is_path || r_type == pap_pkg::T_ATOMIC || hasval(r_type);
        sz4 = (r_type == pap_pkg::T_AS4PATH) || i_four_byte_as;
        hl = {15'd0, 2'd3} + {16'd0, r_flags[0]};
        len_now = (r_phase == pap_pkg::PH_LEN2) ? (r_vlen | {8'd0, i_byte}) : {8'd0, i_byte};
        hs = hstat(r_type, r_flags, len_now, i_four_byte_as);
        cnt1 = r_vcnt + 16'd1;
        alen = sz4 ? {7'd0, i_byte, 2'b00} : {8'd0, i_byte, 1'b0};
        vsum = {1'b0, cnt1} + alen;
        asm_sh = {r_asm[23:0], i_byte};
        sl1 = r_sleft - 11'd1;
        mod0 = sz4 ? (sl1[1:0] == 2'b00) : !sl1[0];
        if (fire) begin
            if (r_disc) begin
                if (i_last) begin
                    n_disc = 1'b0; n_phase = pap_pkg::PH_FLAGS;
                end
            end else begin
                unique case (r_phase) inside
                    pap_pkg::PH_FLAGS: begin
                        n_flags = i_byte[7:4];
                        n_type = '0; n_vlen = '0; n_vcnt = '0; n_pend = pap_pkg::ST_OK;
                        n_asm = '0; n_sec = '0; n_sph = pap_pkg::SG_TYPE; n_segt = '0;
                        n_sleft = '0;
                        if (i_last) begin
                            res[0] = mk(pap_pkg::K_DONE, 8'd0, i_byte[7:4], pap_pkg::ST_TRUNC,
                                        8'd0, 32'd0, 32'd0, 17'd1);
                            nres = 2'd1;
                        end else n_phase = pap_pkg::PH_TYPE;
                    end
                    pap_pkg::PH_TYPE: begin
                        n_type = i_byte;
                        if (i_last) begin
                            res[0] = mk(pap_pkg::K_DONE, i_byte, r_flags, pap_pkg::ST_TRUNC,
                                        8'd0, 32'd0, 32'd0, 17'd2);
                            nres = 2'd1; n_phase = pap_pkg::PH_FLAGS;
                        end else n_phase = pap_pkg::PH_LEN1;
                    end
                    pap_pkg::PH_LEN1, pap_pkg::PH_LEN2: begin
                        if (r_phase == pap_pkg::PH_LEN1 && r_flags[0]) begin
                            n_vlen = {i_byte, 8'd0};
                            if (i_last) begin
                                res[0] = mk(pap_pkg::K_DONE, r_type, r_flags,
                                            pap_pkg::ST_TRUNC, 8'd0, 32'd0, 32'd0, 17'd3);
                                nres = 2'd1; n_phase = pap_pkg::PH_FLAGS;
                            end else n_phase = pap_pkg::PH_LEN2;
                        end else begin
                            n_vlen = len_now;
                            n_pend = hs; n_phase = pap_pkg::PH_VALUE;
                            n_sph = pap_pkg::SG_TYPE;
                            if (len_now == 16'd0 || i_last) begin
                                res[0] = mk(pap_pkg::K_DONE, r_type, r_flags,
                                            (len_now == 16'd0) ? hs : pap_pkg::ST_TRUNC,
                                            8'd0,
                                            (len_now == 16'd0 && hs == pap_pkg::ST_OK &&
                                             hasval(r_type)) ? r_asm : 32'd0,
                                            (len_now == 16'd0 && hs == pap_pkg::ST_OK &&
                                             (r_type == pap_pkg::T_AGGR ||
                                              r_type == pap_pkg::T_AS4AGGR)) ? r_sec : 32'd0,
                                            hl);
                                nres = 2'd1; n_phase = pap_pkg::PH_FLAGS;
                                if (((len_now == 16'd0) ? hs : pap_pkg::ST_TRUNC)
                                    != pap_pkg::ST_OK && !i_last) n_disc = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_vcnt = cnt1;
                        if (r_pend == pap_pkg::ST_OK) begin
                            if (is_path) begin
                                unique case (r_sph)
                                    pap_pkg::SG_COUNT: begin
                                        if (vsum > {1'b0, r_vlen})
                                            n_pend = pap_pkg::ST_PATH;
                                        else if (i_byte == 8'd0) n_sph = pap_pkg::SG_TYPE;
                                        else begin
                                            n_sleft = alen[10:0]; n_sph = pap_pkg::SG_ASN;
                                            n_asm = '0;
                                        end
                                    end
                                    pap_pkg::SG_ASN: begin
                                        n_asm = asm_sh; n_sleft = sl1;
                                        if (mod0) begin
                                            res[0] = mk(pap_pkg::K_ASN, r_type, r_flags,
                                                        pap_pkg::ST_OK, r_segt, asm_sh,
                                                        32'd0, 17'd0);
                                            nres = 2'd1; n_asm = '0;
                                        end
                                        if (sl1 == 11'd0) n_sph = pap_pkg::SG_TYPE;
                                    end
                                    default: begin
                                        if (r_vlen - (cnt1 - 16'd1) < 16'd3)
                                            n_pend = pap_pkg::ST_PATH;
                                        else begin
                                            n_segt = i_byte; n_sph = pap_pkg::SG_COUNT;
                                        end
                                    end
                                endcase
                            end else if (known) begin
                                n_asm = asm_sh;
                                if (r_type == pap_pkg::T_ORIGIN && i_byte > 8'd2)
                                    n_pend = pap_pkg::ST_ORIGIN;
                                if ((r_type == pap_pkg::T_AGGR &&
                                     cnt1 == (i_four_byte_as ? 16'd4 : 16'd2)) ||
                                    (r_type == pap_pkg::T_AS4AGGR && cnt1 == 16'd4)) begin
                                    n_sec = asm_sh; n_asm = '0;
                                end
                            end else begin
                                res[0] = mk(pap_pkg::K_RAW, r_type, r_flags, pap_pkg::ST_OK,
                                            8'd0, {24'd0, i_byte}, 32'd0, 17'd0);
                                nres = 2'd1;
                            end
                        end
                        if (cnt1 >= r_vlen || i_last) begin
                            res[nres[0]] = mk(pap_pkg::K_DONE, r_type, r_flags,
                                (cnt1 >= r_vlen) ? n_pend : pap_pkg::ST_TRUNC, 8'd0,
                                ((cnt1 >= r_vlen) && n_pend == pap_pkg::ST_OK && hasval(r_type))
                                    ? n_asm : 32'd0,
                                ((cnt1 >= r_vlen) && n_pend == pap_pkg::ST_OK &&
                                 (r_type == pap_pkg::T_AGGR || r_type == pap_pkg::T_AS4AGGR))
                                    ? n_sec : 32'd0,
                                hl + {1'b0, cnt1});
                            if (((cnt1 >= r_vlen) ? n_pend : pap_pkg::ST_TRUNC)
                                != pap_pkg::ST_OK && !i_last) n_disc = 1'b1;
                            nres = nres + 2'd1; n_phase = pap_pkg::PH_FLAGS;
                        end
                    end
                endcase
            end
        end
        if (nres == 2'd2) res[1].run_end = 1'b1;
        else res[0].run_end = 1'b1;
        o_push = fire && (nres != 2'd0);
        o_pair.two = (nres == 2'd2);
        o_pair.r0 = res[0];
        o_pair.r1 = res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pap_pkg::PH_FLAGS; r_flags <= '0; r_type <= '0; r_vlen <= '0;
            r_vcnt <= '0; r_sph <= pap_pkg::SG_TYPE; r_segt <= '0; r_sleft <= '0;
            r_asm <= '0; r_sec <= '0; r_pend <= pap_pkg::ST_OK; r_disc <= 1'b0;
        end else begin
            r_phase <= n_phase; r_flags <= n_flags; r_type <= n_type; r_vlen <= n_vlen;
            r_vcnt <= n_vcnt; r_sph <= n_sph; r_segt <= n_segt; r_sleft <= n_sleft;
            r_asm <= n_asm; r_sec <= n_sec; r_pend <= n_pend; r_disc <= n_disc;
        end
    end
endmodule

// ===== design/pap_queue.sv =====
module pap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pap_pkg::t_pair i_pair,
    output logic           o_full,
    output logic           o_valid,
    output pap_pkg::t_result o_res,
    input  logic           i_ready
);
    localparam int DEPTH = 4;
    pap_pkg::t_pair r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       r_sub;
    logic       pop, pop_entry;

    assign o_valid = (r_cnt != 3'd0);
    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_res   = r_sub ? r_mem[r_rp].r1 : r_mem[r_rp].r0;
    assign pop       = o_valid && i_ready;
    assign pop_entry = pop && (r_sub || !r_mem[r_rp].two);

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= 1'b0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 2'd1;
            if (pop_entry) begin
                r_rp <= r_rp + 2'd1; r_sub <= 1'b0;
            end else if (pop) r_sub <= 1'b1;
            r_cnt <= r_cnt + {2'd0, (i_push && !o_full)} - {2'd0, pop_entry};
        end
    end
endmodule

// ===== design/path_attribute_parser.sv =====
// channel | dir | payload
// i_in    | in  | in_byte, in_last
// o_out   | out | kind .. run_end
// One byte accepted per cycle while the queue is not full; the front
// decodes it and pushes up to two results, sharing one entry, into a
// 4-entry queue. A result shows on o_out once those ahead have drained.
// The back drains one result per cycle while o_out.ready is high.
// Sync active-low reset clears state and queue; four_byte_as resets to 0.
// In-ready drops only when the queue is full.
module path_attribute_parser (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    pap_in_if.sink  i_in,
    pap_out_if.source o_out
);
    logic r_fba;
    logic q_full, push;
    pap_pkg::t_pair pair;
    pap_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fba <= 1'b0;
        else if (i_cfg_we) r_fba <= i_cfg_wdata;
    end

    pap_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_four_byte_as(r_fba),
        .i_valid(i_in.valid), .i_byte(i_in.in_byte), .i_last(i_in.in_last),
        .i_q_full(q_full), .o_ready(i_in.ready), .o_push(push), .o_pair(pair)
    );

    pap_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_pair(pair),
        .o_full(q_full), .o_valid(o_out.valid), .o_res(res), .i_ready(o_out.ready)
    );

    assign o_out.kind           = res.kind;
    assign o_out.attr_type      = res.attr_type;
    assign o_out.attr_flags     = res.attr_flags;
    assign o_out.status         = res.status;
    assign o_out.segment_type   = res.segment_type;
    assign o_out.data           = res.data;
    assign o_out.agg_asn        = res.agg_asn;
    assign o_out.consumed       = res.consumed;
    assign o_out.run_end        = res.run_end;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !i_in.ready) else $error("accept while queue full");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == pap_pkg::K_DONE) |-> o_out.run_end)
        else $error("done not last");
    a_asn_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != pap_pkg::K_DONE) |-> o_out.status == pap_pkg::ST_OK)
        else $error("status on non-done");
endmodule
